### rtl/bms_response_frame_checker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the response frame checker
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef BMS_RESPONSE_FRAME_CHECKER_MACROS_SVH
`define BMS_RESPONSE_FRAME_CHECKER_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define BMSRFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmsrfc assertion failed");

// condition in this cycle implies consequence in the next cycle
`define BMSRFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmsrfc assertion failed");

`endif

### rtl/bmsrfc_pkg.sv
// ----------------------------------------------------------------------------
// bmsrfc_pkg
// Shared types and constants of the response frame checker.
// ----------------------------------------------------------------------------
package bmsrfc_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LEN_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0]        CRC_INIT  = 16'hFFFF;
    localparam logic [15:0]        CRC_POLY  = 16'hA001;

    // byte positions inside a frame
    localparam logic [COUNT_W-1:0] POS_START    = 17'd0;
    localparam logic [COUNT_W-1:0] POS_ADDRESS  = 17'd1;
    localparam logic [COUNT_W-1:0] POS_HOST     = 17'd2;
    localparam logic [COUNT_W-1:0] POS_RW_FLAG  = 17'd3;
    localparam logic [COUNT_W-1:0] POS_COMMAND  = 17'd4;
    localparam logic [COUNT_W-1:0] POS_LEN_HI   = 17'd5;
    localparam logic [COUNT_W-1:0] POS_LEN_LO   = 17'd6;
    localparam logic [COUNT_W-1:0] POS_PAYLOAD  = 17'd7;
    localparam logic [COUNT_W-1:0] POS_MIN_LAST = 17'd8;
    // header plus CRC bytes beyond the payload, counted to the last byte index
    localparam logic [COUNT_W-1:0] FRAME_OVERHEAD_LAST = 17'd8;
    // first byte position at which the CRC folds in the byte from two transfers back
    localparam logic [COUNT_W-1:0] POS_CRC_FOLD = 17'd3;

    typedef enum logic [3:0] {
        ERR_NONE    = 4'd0,
        ERR_SHORT   = 4'd1,
        ERR_START   = 4'd2,
        ERR_ADDRESS = 4'd3,
        ERR_HOST    = 4'd4,
        ERR_RW_FLAG = 4'd5,
        ERR_COMMAND = 4'd6,
        ERR_LENGTH  = 4'd7,
        ERR_CRC     = 4'd8
    } err_code_t;

    typedef enum logic [2:0] {
        CFG_START   = 3'd0,
        CFG_ADDRESS = 3'd1,
        CFG_HOST    = 3'd2,
        CFG_RW_FLAG = 3'd3,
        CFG_COMMAND = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic advance;    // a byte transfer is taken this cycle
        logic fold;       // fold the byte two positions back
        logic frame_end;  // reload the accumulator
    } crc_ctrl_t;

endpackage

### rtl/bmsrfc_crc.sv
// ----------------------------------------------------------------------------
// bmsrfc_crc
// Reflected CRC-16 accumulator (poly 0xA001), one byte folded per transfer.
// ----------------------------------------------------------------------------
module bmsrfc_crc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmsrfc_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]            data_byte,
    output logic [15:0]           crc_value
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_folded;

    always_comb
    begin
        logic [15:0] acc;
        acc = crc_reg ^ {8'h00, data_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ bmsrfc_pkg::CRC_POLY;
            else
                acc = acc >> 1;
        end
        crc_folded = acc;
    end

    // value after this transfer's fold, used for the CRC compare on the last byte
    assign crc_value = ctrl.fold ? crc_folded : crc_reg;

    always_comb
    begin
        crc_next = crc_reg;
        if (ctrl.advance)
        begin
            if (ctrl.frame_end)
                crc_next = bmsrfc_pkg::CRC_INIT;
            else
                crc_next = crc_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= bmsrfc_pkg::CRC_INIT;
        else
            crc_reg <= crc_next;
    end

endmodule

### rtl/bms_response_frame_checker.sv
// ----------------------------------------------------------------------------
// bms_response_frame_checker
// An accepted input transfer's result appears in the output register in the next cycle.
// Throughput: one byte per cycle; the output register is the only stage, and it
// takes a new byte whenever it is empty or its result leaves in the same cycle.
// Reset: asynchronous, active low; clears the frame state, the CRC to 0xFFFF,
// the configuration registers to zero and the output register to empty.
// ----------------------------------------------------------------------------
`include "bms_response_frame_checker_macros.svh"

module bms_response_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_frame,
    // results
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  payload_byte,
    output logic        payload_valid,
    output logic [15:0] payload_index,
    output logic        frame_done,
    output logic        frame_ok,
    output logic [3:0]  error_code,
    output logic [15:0] payload_length
);

    // configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] node_address_reg;
    logic [7:0] host_id_reg;
    logic [7:0] read_flag_reg;
    logic [7:0] command_reg;

    // frame state
    logic [bmsrfc_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                     delay0_reg, delay0_next;
    logic [7:0]                     delay1_reg, delay1_next;
    logic [bmsrfc_pkg::LEN_W-1:0]   length_reg, length_next;
    bmsrfc_pkg::err_code_t          first_err_reg, first_err_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  pbyte_reg, pbyte_next;
    logic        pvalid_reg, pvalid_next;
    logic [15:0] pindex_reg, pindex_next;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;
    bmsrfc_pkg::err_code_t err_reg, err_next;
    logic [15:0] plen_reg, plen_next;

    logic                  accept;
    logic                  out_take;
    bmsrfc_pkg::crc_ctrl_t crc_ctrl;
    logic [15:0]           crc_value;

    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign crc_ctrl.advance   = accept;
    assign crc_ctrl.fold      = (count_reg >= bmsrfc_pkg::POS_CRC_FOLD);
    assign crc_ctrl.frame_end = end_of_frame;

    bmsrfc_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (crc_ctrl),
        .data_byte (delay1_reg),
        .crc_value (crc_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= '0;
            node_address_reg <= '0;
            host_id_reg      <= '0;
            read_flag_reg    <= '0;
            command_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (bmsrfc_pkg::cfg_index_t'(cfg_index))
                bmsrfc_pkg::CFG_START:   start_byte_reg   <= cfg_data;
                bmsrfc_pkg::CFG_ADDRESS: node_address_reg <= cfg_data;
                bmsrfc_pkg::CFG_HOST:    host_id_reg      <= cfg_data;
                bmsrfc_pkg::CFG_RW_FLAG: read_flag_reg    <= cfg_data;
                bmsrfc_pkg::CFG_COMMAND: command_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [bmsrfc_pkg::COUNT_W-1:0] offset;
        logic                           in_payload;
        bmsrfc_pkg::err_code_t          err_now;

        length_next    = length_reg;
        first_err_next = first_err_reg;
        count_next     = count_reg;
        delay0_next    = delay0_reg;
        delay1_next    = delay1_reg;
        err_now        = bmsrfc_pkg::ERR_NONE;

        // header compares and length capture
        unique case (count_reg)
            bmsrfc_pkg::POS_START:
                if (rx_byte != start_byte_reg) err_now = bmsrfc_pkg::ERR_START;
            bmsrfc_pkg::POS_ADDRESS:
                if (rx_byte != node_address_reg) err_now = bmsrfc_pkg::ERR_ADDRESS;
            bmsrfc_pkg::POS_HOST:
                if (rx_byte != host_id_reg) err_now = bmsrfc_pkg::ERR_HOST;
            bmsrfc_pkg::POS_RW_FLAG:
                if (rx_byte != read_flag_reg) err_now = bmsrfc_pkg::ERR_RW_FLAG;
            bmsrfc_pkg::POS_COMMAND:
                if (rx_byte != command_reg) err_now = bmsrfc_pkg::ERR_COMMAND;
            bmsrfc_pkg::POS_LEN_HI:
                length_next = {rx_byte, 8'h00};
            bmsrfc_pkg::POS_LEN_LO:
                length_next = {length_reg[15:8], rx_byte};
            default: ;
        endcase

        if (first_err_reg == bmsrfc_pkg::ERR_NONE)
            first_err_next = err_now;

        offset     = count_reg - bmsrfc_pkg::POS_PAYLOAD;
        in_payload = (count_reg >= bmsrfc_pkg::POS_PAYLOAD) &&
                     (offset < {1'b0, length_next});

        pbyte_next  = in_payload ? rx_byte : 8'h00;
        pvalid_next = in_payload;
        pindex_next = in_payload ? offset[15:0] : 16'h0000;
        done_next   = end_of_frame;
        err_next    = bmsrfc_pkg::ERR_NONE;
        plen_next   = 16'h0000;

        if (end_of_frame)
        begin
            if (count_reg >= bmsrfc_pkg::POS_LEN_LO)
                plen_next = length_next;
            if (count_reg < bmsrfc_pkg::POS_MIN_LAST)
                err_next = bmsrfc_pkg::ERR_SHORT;
            else if (first_err_reg != bmsrfc_pkg::ERR_NONE)
                err_next = first_err_reg;
            else if (({1'b0, length_reg} + bmsrfc_pkg::FRAME_OVERHEAD_LAST) != count_reg)
                err_next = bmsrfc_pkg::ERR_LENGTH;
            else if (crc_value != {delay0_reg, rx_byte})
                err_next = bmsrfc_pkg::ERR_CRC;
            // return the frame state to reset values
            count_next     = '0;
            delay0_next    = 8'h00;
            delay1_next    = 8'h00;
            length_next    = '0;
            first_err_next = bmsrfc_pkg::ERR_NONE;
        end
        else
        begin
            delay1_next = delay0_reg;
            delay0_next = rx_byte;
            if (count_reg != bmsrfc_pkg::COUNT_MAX)
                count_next = count_reg + 1'b1;
        end

        ok_next = end_of_frame && (err_next == bmsrfc_pkg::ERR_NONE);

        // output register empties on a take and refills on an accept
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            delay0_reg    <= '0;
            delay1_reg    <= '0;
            length_reg    <= '0;
            first_err_reg <= bmsrfc_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg     <= count_next;
                delay0_reg    <= delay0_next;
                delay1_reg    <= delay1_next;
                length_reg    <= length_next;
                first_err_reg <= first_err_next;
            end
        end
    end

    // result payload: no reset, loaded on each accepted transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pbyte_reg  <= pbyte_next;
            pvalid_reg <= pvalid_next;
            pindex_reg <= pindex_next;
            done_reg   <= done_next;
            ok_reg     <= ok_next;
            err_reg    <= err_next;
            plen_reg   <= plen_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = pbyte_reg;
    assign payload_valid  = pvalid_reg;
    assign payload_index  = pindex_reg;
    assign frame_done     = done_reg;
    assign frame_ok       = ok_reg;
    assign error_code     = err_reg;
    assign payload_length = plen_reg;

    `BMSRFC_ASSERT_SAME(a_ok_means_clean, out_valid && frame_ok, frame_done && (error_code == bmsrfc_pkg::ERR_NONE))
    `BMSRFC_ASSERT_SAME(a_mid_frame_quiet, out_valid && !frame_done, (error_code == bmsrfc_pkg::ERR_NONE) && (payload_length == 16'h0000))
    `BMSRFC_ASSERT_NEXT(a_frame_end_clears, accept && end_of_frame, (count_reg == '0) && (first_err_reg == bmsrfc_pkg::ERR_NONE) && (u_crc.crc_value == bmsrfc_pkg::CRC_INIT))
    `BMSRFC_ASSERT_NEXT(a_accept_fills_output, accept, out_valid)

endmodule
